@@ sv/rlca_pkg.sv @@
// rlca_pkg: shared constants and types for the ray/line closest-approach unit.
// No dependencies.
package rlca_pkg;

    localparam int DEF_COORD_WIDTH      = 16;
    localparam int DEF_COORD_FRAC_BITS  = 8;
    localparam int DEF_RESULT_FRAC_BITS = 16;

    localparam int RES_W  = 32;
    localparam int DIV_Q_W = 64;
    localparam int ROOT_W = 32;

    localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] SAT_U   = {RES_W{1'b1}};

    typedef struct packed {
        logic [RES_W-1:0] ray_param;
        logic [RES_W-1:0] line_param;
        logic             parallel;
        logic             dist_sat;
    } rlca_side_t;

endpackage

@@ sv/rlca_front.sv @@
// rlca_front: eight-stage front end forming n = r x D, |n|^2, both ratio
// numerators (as sign and magnitude) and |w.n|^2. Depends on rlca_pkg.
module rlca_front
    import rlca_pkg::*;
#(
    parameter int CW = DEF_COORD_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [CW-1:0]     o_x,
    input  logic signed [CW-1:0]     o_y,
    input  logic signed [CW-1:0]     o_z,
    input  logic signed [CW-1:0]     r_x,
    input  logic signed [CW-1:0]     r_y,
    input  logic signed [CW-1:0]     r_z,
    input  logic signed [CW-1:0]     a_x,
    input  logic signed [CW-1:0]     a_y,
    input  logic signed [CW-1:0]     a_z,
    input  logic signed [CW-1:0]     b_x,
    input  logic signed [CW-1:0]     b_y,
    input  logic signed [CW-1:0]     b_z,
    output logic                     out_valid,
    output logic                     par,
    output logic                     sign1,
    output logic                     sign2,
    output logic [4*CW+6:0]          mag1,
    output logic [4*CW+6:0]          mag2,
    output logic [4*CW+5:0]          n2,
    output logic [6*CW+9:0]          wn2
);

    localparam int DW    = CW + 1;
    localparam int PW    = 2 * CW + 1;
    localparam int PCW   = 2 * CW + 2;
    localparam int NW    = 2 * CW + 2;
    localparam int C1W   = 2 * CW + 3;
    localparam int N2W   = 4 * CW + 6;
    localparam int NUMW  = 4 * CW + 7;
    localparam int WNW   = 3 * CW + 5;
    localparam int WN2W  = 2 * WNW;
    localparam int LO    = (WNW + 1) / 2;
    localparam int HI    = WNW - LO;

    logic signed [CW-1:0] o_in [3];
    logic signed [CW-1:0] r_in [3];
    logic signed [CW-1:0] a_in [3];
    logic signed [CW-1:0] b_in [3];

    logic [8:1] v_reg;

    logic signed [CW-1:0]      r1_reg [3];
    logic signed [DW-1:0]      d1_reg [3];
    logic signed [DW-1:0]      w1_reg [3];
    logic signed [PW-1:0]      pn2_reg [6];
    logic signed [PCW-1:0]     pc12_reg [6];
    logic signed [PW-1:0]      pc22_reg [6];
    logic signed [DW-1:0]      w2_reg [3];
    logic signed [NW-1:0]      n3_reg [3];
    logic signed [C1W-1:0]     c13_reg [3];
    logic signed [NW-1:0]      c23_reg [3];
    logic signed [DW-1:0]      w3_reg [3];
    logic signed [2*NW-1:0]    sq4_reg [3];
    logic signed [C1W+NW-1:0]  t14_reg [3];
    logic signed [2*NW-1:0]    t24_reg [3];
    logic signed [DW+NW-1:0]   u4_reg [3];
    logic [N2W-1:0]            n2_5_reg;
    logic signed [NUMW-1:0]    num1_5_reg;
    logic signed [NUMW-1:0]    num2_5_reg;
    logic signed [WNW-1:0]     wn5_reg;
    logic [N2W-1:0]            n2_6_reg, n2_7_reg, n2_8_reg;
    logic [NUMW-1:0]           mag1_6_reg, mag1_7_reg, mag1_8_reg;
    logic [NUMW-1:0]           mag2_6_reg, mag2_7_reg, mag2_8_reg;
    logic [2:0]                s1_reg, s2_reg, par_reg;
    logic [WNW-1:0]            mwn6_reg;
    logic [2*HI-1:0]           hh7_reg;
    logic [HI+LO-1:0]          hl7_reg;
    logic [2*LO-1:0]           ll7_reg;
    logic [WN2W-1:0]           wn2_8_reg;

    assign o_in = '{o_x, o_y, o_z};
    assign r_in = '{r_x, r_y, r_z};
    assign a_in = '{a_x, a_y, a_z};
    assign b_in = '{b_x, b_y, b_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[7:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r1_reg[i] <= r_in[i];
                d1_reg[i] <= $signed({b_in[i][CW-1], b_in[i]}) - $signed({a_in[i][CW-1], a_in[i]});
                w1_reg[i] <= $signed({a_in[i][CW-1], a_in[i]}) - $signed({o_in[i][CW-1], o_in[i]});
            end

            // cross products: x = a1*b2 - a2*b1, y = a2*b0 - a0*b2, z = a0*b1 - a1*b0
            pn2_reg[0]  <= r1_reg[1] * d1_reg[2];
            pn2_reg[1]  <= r1_reg[2] * d1_reg[1];
            pn2_reg[2]  <= r1_reg[2] * d1_reg[0];
            pn2_reg[3]  <= r1_reg[0] * d1_reg[2];
            pn2_reg[4]  <= r1_reg[0] * d1_reg[1];
            pn2_reg[5]  <= r1_reg[1] * d1_reg[0];
            pc12_reg[0] <= w1_reg[1] * d1_reg[2];
            pc12_reg[1] <= w1_reg[2] * d1_reg[1];
            pc12_reg[2] <= w1_reg[2] * d1_reg[0];
            pc12_reg[3] <= w1_reg[0] * d1_reg[2];
            pc12_reg[4] <= w1_reg[0] * d1_reg[1];
            pc12_reg[5] <= w1_reg[1] * d1_reg[0];
            pc22_reg[0] <= w1_reg[1] * r1_reg[2];
            pc22_reg[1] <= w1_reg[2] * r1_reg[1];
            pc22_reg[2] <= w1_reg[2] * r1_reg[0];
            pc22_reg[3] <= w1_reg[0] * r1_reg[2];
            pc22_reg[4] <= w1_reg[0] * r1_reg[1];
            pc22_reg[5] <= w1_reg[1] * r1_reg[0];
            w2_reg      <= w1_reg;

            for (int i = 0; i < 3; i++)
            begin
                n3_reg[i]  <= pn2_reg[2*i] - pn2_reg[2*i+1];
                c13_reg[i] <= pc12_reg[2*i] - pc12_reg[2*i+1];
                c23_reg[i] <= pc22_reg[2*i] - pc22_reg[2*i+1];
            end
            w3_reg <= w2_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq4_reg[i] <= n3_reg[i] * n3_reg[i];
                t14_reg[i] <= c13_reg[i] * n3_reg[i];
                t24_reg[i] <= c23_reg[i] * n3_reg[i];
                u4_reg[i]  <= w3_reg[i] * n3_reg[i];
            end

            n2_5_reg   <= N2W'($unsigned(sq4_reg[0])) + N2W'($unsigned(sq4_reg[1]))
                          + N2W'($unsigned(sq4_reg[2]));
            num1_5_reg <= NUMW'(t14_reg[0]) + NUMW'(t14_reg[1]) + NUMW'(t14_reg[2]);
            num2_5_reg <= NUMW'(t24_reg[0]) + NUMW'(t24_reg[1]) + NUMW'(t24_reg[2]);
            wn5_reg    <= WNW'(u4_reg[0]) + WNW'(u4_reg[1]) + WNW'(u4_reg[2]);

            n2_6_reg   <= n2_5_reg;
            par_reg[0] <= (n2_5_reg == '0);
            s1_reg[0]  <= num1_5_reg[NUMW-1];
            s2_reg[0]  <= num2_5_reg[NUMW-1];
            mag1_6_reg <= num1_5_reg[NUMW-1] ? NUMW'(-num1_5_reg) : NUMW'(num1_5_reg);
            mag2_6_reg <= num2_5_reg[NUMW-1] ? NUMW'(-num2_5_reg) : NUMW'(num2_5_reg);
            mwn6_reg   <= wn5_reg[WNW-1] ? WNW'(-wn5_reg) : WNW'(wn5_reg);

            // |w.n|^2 from half-width partial products
            hh7_reg    <= mwn6_reg[WNW-1:LO] * mwn6_reg[WNW-1:LO];
            hl7_reg    <= mwn6_reg[WNW-1:LO] * mwn6_reg[LO-1:0];
            ll7_reg    <= mwn6_reg[LO-1:0] * mwn6_reg[LO-1:0];
            n2_7_reg   <= n2_6_reg;
            mag1_7_reg <= mag1_6_reg;
            mag2_7_reg <= mag2_6_reg;
            par_reg[1] <= par_reg[0];
            s1_reg[1]  <= s1_reg[0];
            s2_reg[1]  <= s2_reg[0];

            wn2_8_reg  <= (WN2W'(hh7_reg) << (2 * LO)) + (WN2W'(hl7_reg) << (LO + 1))
                          + WN2W'(ll7_reg);
            n2_8_reg   <= n2_7_reg;
            mag1_8_reg <= mag1_7_reg;
            mag2_8_reg <= mag2_7_reg;
            par_reg[2] <= par_reg[1];
            s1_reg[2]  <= s1_reg[1];
            s2_reg[2]  <= s2_reg[1];
        end
    end

    assign out_valid = v_reg[8];
    assign par       = par_reg[2];
    assign sign1     = s1_reg[2];
    assign sign2     = s2_reg[2];
    assign mag1      = mag1_8_reg;
    assign mag2      = mag2_8_reg;
    assign n2        = n2_8_reg;
    assign wn2       = wn2_8_reg;

endmodule

@@ sv/rlca_div.sv @@
// rlca_div: pipelined restoring divider, one quotient bit per stage, with
// overflow flag and a sideband carried alongside. Depends on rlca_pkg.
module rlca_div
    import rlca_pkg::*;
#(
    parameter int NUM_W  = 96,
    parameter int DEN_W  = 70,
    parameter int Q_W    = DIV_Q_W,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic              ovf,
    output logic [SIDE_W-1:0] side_out
);

    localparam int EXT_W = (NUM_W > Q_W + DEN_W) ? NUM_W : Q_W + DEN_W;
    localparam int HI_W  = EXT_W - Q_W;

    logic [EXT_W-1:0]  num_ext;
    logic [HI_W-1:0]   num_hi;

    logic              valid_reg [0:Q_W];
    logic [DEN_W-1:0]  rem_reg   [0:Q_W-1];
    logic [DEN_W-1:0]  den_reg   [0:Q_W-1];
    logic [Q_W-1:0]    ql_reg    [0:Q_W];
    logic              ovf_reg   [0:Q_W];
    logic [SIDE_W-1:0] side_reg  [0:Q_W];

    assign num_ext = EXT_W'(num);
    assign num_hi  = num_ext[EXT_W-1:Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Q_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= Q_W; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num_hi[DEN_W-1:0];
            den_reg[0]  <= den;
            ql_reg[0]   <= num_ext[Q_W-1:0];
            ovf_reg[0]  <= (num_hi >= HI_W'(den));
            side_reg[0] <= side_in;
        end
    end

    for (genvar g = 0; g < Q_W; g++)
    begin : g_stage
        logic [DEN_W:0] rem2;
        logic [DEN_W:0] diff;
        logic           take;

        assign rem2 = {rem_reg[g], ql_reg[g][Q_W-1]};
        assign diff = rem2 - {1'b0, den_reg[g]};
        assign take = (rem2 >= {1'b0, den_reg[g]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ql_reg[g+1]   <= {ql_reg[g][Q_W-2:0], take};
                ovf_reg[g+1]  <= ovf_reg[g];
                side_reg[g+1] <= side_reg[g];
            end
        end

        if (g + 1 < Q_W)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1] <= take ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
                    den_reg[g+1] <= den_reg[g];
                end
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quo       = ql_reg[Q_W];
    assign ovf       = ovf_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

@@ sv/rlca_sqrt.sv @@
// rlca_sqrt: pipelined integer square root, one root bit per stage, with a
// sideband carried alongside. Depends on rlca_pkg.
module rlca_sqrt
    import rlca_pkg::*;
#(
    parameter int RW     = ROOT_W,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [RW-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg [0:RW];
    logic [2*RW-1:0]   rad_reg   [0:RW-1];
    logic [RW:0]       rem_reg   [0:RW-1];
    logic [RW-1:0]     root_reg  [0:RW];
    logic [SIDE_W-1:0] side_reg  [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= RW; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= RW; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar g = 0; g < RW; g++)
    begin : g_stage
        logic [RW+2:0] rem2;
        logic [RW+2:0] trial;
        logic [RW+2:0] diff;
        logic          take;

        assign rem2  = {rem_reg[g], rad_reg[g][2*RW-1:2*RW-2]};
        assign trial = {1'b0, root_reg[g], 2'b01};
        assign diff  = rem2 - trial;
        assign take  = (rem2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[g+1] <= {root_reg[g][RW-2:0], take};
                side_reg[g+1] <= side_reg[g];
            end
        end

        if (g + 1 < RW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1] <= take ? diff[RW:0] : rem2[RW:0];
                    rad_reg[g+1] <= {rad_reg[g][2*RW-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign root      = root_reg[RW];
    assign side_out  = side_reg[RW];

endmodule

@@ sv/ray_line_closest_approach_unit.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_ready    ray_origin_*, ray_dir_*, point_a_*, point_b_*
// out       out_valid / out_ready  ray_param, line_param, gap_distance, parallel_flag
//
// One transaction per cycle while out is not stalled; results pass through the
// front end, bit-per-stage divider and square root chains and output register.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
// A stalled output freezes the whole pipeline; in_ready follows it, nothing is dropped.
// Top level: front end, three dividers, square root, output register. Depends on
// rlca_pkg, rlca_front, rlca_div, rlca_sqrt.
module ray_line_closest_approach_unit
    import rlca_pkg::*;
#(
    parameter int COORD_WIDTH      = DEF_COORD_WIDTH,
    parameter int COORD_FRAC_BITS  = DEF_COORD_FRAC_BITS,
    parameter int RESULT_FRAC_BITS = DEF_RESULT_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
    input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
    input  logic signed [COORD_WIDTH-1:0] ray_origin_z,
    input  logic signed [COORD_WIDTH-1:0] ray_dir_x,
    input  logic signed [COORD_WIDTH-1:0] ray_dir_y,
    input  logic signed [COORD_WIDTH-1:0] ray_dir_z,
    input  logic signed [COORD_WIDTH-1:0] point_a_x,
    input  logic signed [COORD_WIDTH-1:0] point_a_y,
    input  logic signed [COORD_WIDTH-1:0] point_a_z,
    input  logic signed [COORD_WIDTH-1:0] point_b_x,
    input  logic signed [COORD_WIDTH-1:0] point_b_y,
    input  logic signed [COORD_WIDTH-1:0] point_b_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [RES_W-1:0]       ray_param,
    output logic signed [RES_W-1:0]       line_param,
    output logic [RES_W-1:0]              gap_distance,
    output logic                          parallel_flag
);

    localparam int CW     = COORD_WIDTH;
    localparam int NUMW   = 4 * CW + 7;
    localparam int N2W    = 4 * CW + 6;
    localparam int WN2W   = 2 * (3 * CW + 5);
    localparam int RAT_NW = NUMW + RESULT_FRAC_BITS;
    localparam int DST_NW = WN2W + 2 * RESULT_FRAC_BITS;
    localparam int DST_DW = N2W + 2 * COORD_FRAC_BITS;
    localparam int SIDE_W = $bits(rlca_side_t);

    logic              en;
    logic              fe_valid, fe_par, fe_sign1, fe_sign2;
    logic [NUMW-1:0]   fe_mag1, fe_mag2;
    logic [N2W-1:0]    fe_n2;
    logic [WN2W-1:0]   fe_wn2;

    logic              dv_valid;
    logic [DIV_Q_W-1:0] q1, q2, qd;
    logic              ovf1, ovf2, ovfd;
    logic              sg1, sg2, par_d;
    rlca_side_t        side_in, side_out;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;

    logic              out_valid_reg;
    logic [RES_W-1:0]  ray_reg, line_reg, gap_reg;
    logic              par_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    rlca_front #(.CW(CW)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .o_x(ray_origin_x), .o_y(ray_origin_y), .o_z(ray_origin_z),
        .r_x(ray_dir_x), .r_y(ray_dir_y), .r_z(ray_dir_z),
        .a_x(point_a_x), .a_y(point_a_y), .a_z(point_a_z),
        .b_x(point_b_x), .b_y(point_b_y), .b_z(point_b_z),
        .out_valid(fe_valid), .par(fe_par), .sign1(fe_sign1), .sign2(fe_sign2),
        .mag1(fe_mag1), .mag2(fe_mag2), .n2(fe_n2), .wn2(fe_wn2)
    );

    rlca_div #(.NUM_W(RAT_NW), .DEN_W(N2W), .Q_W(DIV_Q_W), .SIDE_W(1)) u_div_ray (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(fe_valid),
        .num(RAT_NW'(fe_mag1) << RESULT_FRAC_BITS), .den(fe_n2), .side_in(fe_sign1),
        .out_valid(dv_valid), .quo(q1), .ovf(ovf1), .side_out(sg1)
    );

    rlca_div #(.NUM_W(RAT_NW), .DEN_W(N2W), .Q_W(DIV_Q_W), .SIDE_W(1)) u_div_line (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(fe_valid),
        .num(RAT_NW'(fe_mag2) << RESULT_FRAC_BITS), .den(fe_n2), .side_in(fe_sign2),
        .out_valid(), .quo(q2), .ovf(ovf2), .side_out(sg2)
    );

    rlca_div #(.NUM_W(DST_NW), .DEN_W(DST_DW), .Q_W(DIV_Q_W), .SIDE_W(1)) u_div_dist (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(fe_valid),
        .num(DST_NW'(fe_wn2) << (2 * RESULT_FRAC_BITS)),
        .den(DST_DW'(fe_n2) << (2 * COORD_FRAC_BITS)), .side_in(fe_par),
        .out_valid(), .quo(qd), .ovf(ovfd), .side_out(par_d)
    );

    function automatic logic [RES_W-1:0] sat_s(input logic neg, input logic ovf,
                                               input logic [DIV_Q_W-1:0] q);
        logic [RES_W-1:0] r;
        if (!neg)
        begin
            r = (ovf || q > DIV_Q_W'(SAT_POS)) ? SAT_POS : q[RES_W-1:0];
        end
        else
        begin
            r = (ovf || q > DIV_Q_W'(SAT_NEG)) ? SAT_NEG : RES_W'(-q[RES_W-1:0]);
        end
        return r;
    endfunction

    always_comb
    begin
        side_in.ray_param  = par_d ? '0 : sat_s(sg1, ovf1, q1);
        side_in.line_param = par_d ? '0 : sat_s(sg2, ovf2, q2);
        side_in.parallel   = par_d;
        side_in.dist_sat   = ovfd;
    end

    rlca_sqrt #(.RW(ROOT_W), .SIDE_W(SIDE_W)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dv_valid),
        .rad(qd), .side_in(side_in),
        .out_valid(sq_valid), .root(sq_root), .side_out(side_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray_reg  <= side_out.ray_param;
            line_reg <= side_out.line_param;
            par_reg  <= side_out.parallel;
            if (side_out.parallel)
            begin
                gap_reg <= '0;
            end
            else if (side_out.dist_sat)
            begin
                gap_reg <= SAT_U;
            end
            else
            begin
                gap_reg <= RES_W'(sq_root);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign ray_param     = ray_reg;
    assign line_param    = line_reg;
    assign gap_distance  = gap_reg;
    assign parallel_flag = par_reg;

endmodule

@@ sv/rlca_checker.sv @@
// rlca_checker: port-level assertions for ray_line_closest_approach_unit,
// bound to the top level. Depends on rlca_pkg.
module rlca_checker
    import rlca_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [RES_W-1:0] ray_param,
    input logic [RES_W-1:0] line_param,
    input logic [RES_W-1:0] gap_distance,
    input logic             parallel_flag
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(ray_param) && $stable(line_param)
                                    && $stable(gap_distance) && $stable(parallel_flag))
        else $error("out payload changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not track output stall");

    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parallel_flag |-> ray_param == '0 && line_param == '0
                                       && gap_distance == '0)
        else $error("parallel result carries nonzero fields");

    a_idle_in: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && !out_valid |=> !out_valid || $past(in_ready))
        else $error("unexpected output state");

endmodule

bind ray_line_closest_approach_unit rlca_checker u_rlca_checker (.*);
